// ===== rtl/core/lph_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Landmark pair hashing package
// Widths, window constants, shared types and slot arithmetic.
// ----------------------------------------------------------------------------
package lph_pkg;

   localparam int WINDOW_DEPTH = 32;
   localparam int SLOT_W       = $clog2(WINDOW_DEPTH);
   localparam int CNT_W        = $clog2(WINDOW_DEPTH + 1);
   localparam int TIME_W       = 24;
   localparam int BIN_W        = 16;
   localparam int GAP_W        = 16;
   localparam int REG_W        = 15;
   localparam int ZEND_W       = 16;
   localparam int HASH_W       = 48;
   localparam int CSR_IDX_W    = 4;

   localparam logic [CSR_IDX_W-1:0] REG_ZONE_DELAY = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] REG_ZONE_WIDTH = CSR_IDX_W'(1);

   localparam logic [REG_W-1:0] ZONE_DELAY_RST = REG_W'(1);
   localparam logic [REG_W-1:0] ZONE_WIDTH_RST = REG_W'(32);

   typedef logic [SLOT_W-1:0] slot_type;
   typedef logic [CNT_W-1:0]  cnt_type;

   typedef struct packed {
      logic [TIME_W-1:0] frame;
      logic [BIN_W-1:0]  bin;
   } anchor_type;

   typedef struct packed {
      logic       en;
      slot_type   slot;
      anchor_type data;
   } ram_wr_type;

   typedef struct packed {
      logic [TIME_W-1:0] anchor_frame;
      logic [TIME_W-1:0] peak_frame;
      logic [REG_W-1:0]  zone_delay;
      logic [ZEND_W-1:0] zone_end;
   } pair_req_type;

   typedef struct packed {
      logic             stale;
      logic             hit;
      logic [GAP_W-1:0] gap;
   } pair_res_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_FLUSH,
      ST_STORE
   } state_type;

   function automatic slot_type slot_next(input slot_type s);
      return (s == slot_type'(WINDOW_DEPTH - 1)) ? slot_type'(0) : s + slot_type'(1);
   endfunction

   function automatic slot_type slot_add(input slot_type h, input cnt_type c);
      logic [CNT_W:0] sum;
      sum = (CNT_W + 1)'(h) + (CNT_W + 1)'(c);
      if (sum >= (CNT_W + 1)'(WINDOW_DEPTH)) begin
         sum = sum - (CNT_W + 1)'(WINDOW_DEPTH);
      end
      return sum[SLOT_W-1:0];
   endfunction

endpackage

// ===== rtl/core/lph_ifs.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Landmark pair hashing channels
// Valid/ready channels for peak words, hash words and register writes.
// ----------------------------------------------------------------------------
interface lph_req_if import lph_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [TIME_W-1:0] peak_time;
   logic [BIN_W-1:0]  peak_bin;

   modport source (output valid, peak_time, peak_bin, input ready);
   modport sink   (input valid, peak_time, peak_bin, output ready);
endinterface

interface lph_rsp_if import lph_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [HASH_W-1:0] hash_word;
   logic [TIME_W-1:0] anchor_frame;
   logic              last_of_run;
   logic              anchor_lost;

   modport source (output valid, hash_word, anchor_frame, last_of_run, anchor_lost,
                   input ready);
   modport sink   (input valid, hash_word, anchor_frame, last_of_run, anchor_lost,
                   output ready);
endinterface

interface lph_csr_if import lph_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic [CSR_IDX_W-1:0] reg_index;
   logic [REG_W-1:0]     wdata;

   modport source (output valid, reg_index, wdata, input ready);
   modport sink   (input valid, reg_index, wdata, output ready);
endinterface

// ===== rtl/core/lph_anchor_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Anchor window store
// Circular anchor memory, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module lph_anchor_ram import lph_pkg::*; (
   input  logic       clock,
   input  ram_wr_type wr,
   input  logic       rd_en,
   input  slot_type   rd_slot,
   output anchor_type rd_data
);

   anchor_type mem_ff [WINDOW_DEPTH];
   anchor_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem_ff[wr.slot] <= wr.data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_slot];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/core/lph_pair_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Pair compare unit
// Frame gap of one anchor against the peak and zone classification.
// ----------------------------------------------------------------------------
module lph_pair_unit import lph_pkg::*; (
   input  pair_req_type pair_req,
   output pair_res_type pair_res
);

   logic [TIME_W:0]   diff;
   logic [TIME_W-1:0] gap_full;
   logic              behind;
   logic              far;
   logic              near;

   always_comb begin
      diff     = {1'b0, pair_req.peak_frame} - {1'b0, pair_req.anchor_frame};
      behind   = diff[TIME_W];    // anchor newer than peak
      gap_full = diff[TIME_W-1:0];
      far      = gap_full > TIME_W'(pair_req.zone_end);
      near     = gap_full < TIME_W'(pair_req.zone_delay);

      pair_res.stale = !behind && far;
      pair_res.hit   = !behind && !far && !near;
      pair_res.gap   = gap_full[GAP_W-1:0];
   end

endmodule

// ===== rtl/core/lph_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Landmark pair sequencer
// Scans the anchor window per peak, evicts leading stale anchors, holds one hash
// back to flag the last of a run, and appends the peak to the window.
// ----------------------------------------------------------------------------
module lph_ctrl import lph_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   lph_req_if.sink      req,
   lph_rsp_if.source    rsp,
   lph_csr_if.sink      csr,
   output ram_wr_type   ram_wr,
   output logic         ram_rd_en,
   output slot_type     ram_rd_slot,
   input  anchor_type   ram_rd_data,
   output pair_req_type pair_req,
   input  pair_res_type pair_res
);

   state_type          state_ff, state_in;
   slot_type           head_ff, head_in;
   cnt_type            count_ff, count_in;
   logic               lost_ff, lost_in;
   logic [REG_W-1:0]   delay_ff, delay_in;
   logic [REG_W-1:0]   width_ff, width_in;
   logic [TIME_W-1:0]  frame_ff, frame_in;
   logic [BIN_W-1:0]   bin_ff, bin_in;
   logic [ZEND_W-1:0]  zend_ff, zend_in;
   cnt_type            total_ff, total_in;
   cnt_type            iss_cnt_ff, iss_cnt_in;
   slot_type           iss_slot_ff, iss_slot_in;
   logic               chk_vld_ff, chk_vld_in;
   logic               prefix_ff, prefix_in;
   logic               pend_vld_ff, pend_vld_in;
   logic [HASH_W-1:0]  pend_hash_ff, pend_hash_in;
   logic [TIME_W-1:0]  pend_anchor_ff, pend_anchor_in;
   logic               out_vld_ff, out_vld_in;
   logic [HASH_W-1:0]  out_hash_ff, out_hash_in;
   logic [TIME_W-1:0]  out_anchor_ff, out_anchor_in;
   logic               out_last_ff, out_last_in;
   logic               out_lost_ff, out_lost_in;

   logic              accept;
   logic              issue;
   logic              stall;
   logic              proc;
   logic              out_free;
   logic              lost_now;
   logic              full;
   logic [HASH_W-1:0] new_hash;

   assign pair_req.anchor_frame = ram_rd_data.frame;
   assign pair_req.peak_frame   = frame_ff;
   assign pair_req.zone_delay   = delay_ff;
   assign pair_req.zone_end     = zend_ff;

   assign full     = (count_ff == CNT_W'(WINDOW_DEPTH));
   assign lost_now = lost_ff | full;
   assign out_free = !out_vld_ff || rsp.ready;
   assign stall    = chk_vld_ff && pair_res.hit && pend_vld_ff && out_vld_ff && !rsp.ready;
   assign proc     = chk_vld_ff && !stall;
   assign new_hash = {ram_rd_data.bin, bin_ff, pair_res.gap};

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req.valid) begin
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if ((iss_cnt_ff == total_ff) && !stall) begin
               state_in = ST_FLUSH;
            end
         end
         ST_FLUSH: begin
            if (!pend_vld_ff || out_free) begin
               state_in = ST_STORE;
            end
         end
         ST_STORE: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control outputs
   always_comb begin
      req.ready      = (state_ff == ST_IDLE);
      accept         = req.valid && (state_ff == ST_IDLE);
      issue          = (state_ff == ST_SCAN) && (iss_cnt_ff != total_ff) && !stall;
      ram_rd_en      = issue;
      ram_rd_slot    = iss_slot_ff;
      ram_wr.en      = (state_ff == ST_STORE);
      ram_wr.slot    = full ? head_ff : slot_add(head_ff, count_ff);
      ram_wr.data    = '{frame: frame_ff, bin: bin_ff};
      csr.ready      = 1'b1;
      rsp.valid        = out_vld_ff;
      rsp.hash_word    = out_hash_ff;
      rsp.anchor_frame = out_anchor_ff;
      rsp.last_of_run  = out_last_ff;
      rsp.anchor_lost  = out_lost_ff;
   end

   // datapath
   always_comb begin
      head_in        = head_ff;
      count_in       = count_ff;
      lost_in        = lost_ff;
      delay_in       = delay_ff;
      width_in       = width_ff;
      frame_in       = frame_ff;
      bin_in         = bin_ff;
      zend_in        = zend_ff;
      total_in       = total_ff;
      iss_cnt_in     = iss_cnt_ff;
      iss_slot_in    = iss_slot_ff;
      chk_vld_in     = chk_vld_ff;
      prefix_in      = prefix_ff;
      pend_vld_in    = pend_vld_ff;
      pend_hash_in   = pend_hash_ff;
      pend_anchor_in = pend_anchor_ff;
      out_vld_in     = out_vld_ff && !rsp.ready;
      out_hash_in    = out_hash_ff;
      out_anchor_in  = out_anchor_ff;
      out_last_in    = out_last_ff;
      out_lost_in    = out_lost_ff;

      if (csr.valid) begin
         unique case (csr.reg_index)
            REG_ZONE_DELAY: delay_in = csr.wdata;
            REG_ZONE_WIDTH: width_in = csr.wdata;
            default: ;
         endcase
      end

      if (accept) begin
         frame_in    = req.peak_time;
         bin_in      = req.peak_bin;
         zend_in     = ZEND_W'(delay_ff) + ZEND_W'(width_ff);
         total_in    = count_ff;
         iss_cnt_in  = '0;
         iss_slot_in = head_ff;
         prefix_in   = 1'b1;
      end

      if (issue) begin
         iss_cnt_in  = iss_cnt_ff + cnt_type'(1);
         iss_slot_in = slot_next(iss_slot_ff);
      end
      if (!stall) begin
         chk_vld_in = issue;
      end

      if (proc) begin
         // evict leading anchors that fell behind the zone
         if (prefix_ff && pair_res.stale) begin
            head_in  = slot_next(head_ff);
            count_in = count_ff - cnt_type'(1);
         end
         if (!pair_res.stale) begin
            prefix_in = 1'b0;
         end
         if (pair_res.hit) begin
            if (pend_vld_ff) begin
               out_vld_in    = 1'b1;
               out_hash_in   = pend_hash_ff;
               out_anchor_in = pend_anchor_ff;
               out_last_in   = 1'b0;
               out_lost_in   = lost_now;
            end
            pend_vld_in    = 1'b1;
            pend_hash_in   = new_hash;
            pend_anchor_in = ram_rd_data.frame;
         end
      end

      if ((state_ff == ST_FLUSH) && pend_vld_ff && out_free) begin
         out_vld_in    = 1'b1;
         out_hash_in   = pend_hash_ff;
         out_anchor_in = pend_anchor_ff;
         out_last_in   = 1'b1;
         out_lost_in   = lost_now;
         pend_vld_in   = 1'b0;
      end

      if (state_ff == ST_STORE) begin
         if (full) begin
            head_in = slot_next(head_ff);
            lost_in = 1'b1;
         end else begin
            count_in = count_ff + cnt_type'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         head_ff     <= '0;
         count_ff    <= '0;
         lost_ff     <= 1'b0;
         delay_ff    <= ZONE_DELAY_RST;
         width_ff    <= ZONE_WIDTH_RST;
         total_ff    <= '0;
         iss_cnt_ff  <= '0;
         chk_vld_ff  <= 1'b0;
         prefix_ff   <= 1'b0;
         pend_vld_ff <= 1'b0;
         out_vld_ff  <= 1'b0;
      end else begin
         state_ff    <= state_in;
         head_ff     <= head_in;
         count_ff    <= count_in;
         lost_ff     <= lost_in;
         delay_ff    <= delay_in;
         width_ff    <= width_in;
         total_ff    <= total_in;
         iss_cnt_ff  <= iss_cnt_in;
         chk_vld_ff  <= chk_vld_in;
         prefix_ff   <= prefix_in;
         pend_vld_ff <= pend_vld_in;
         out_vld_ff  <= out_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      frame_ff       <= frame_in;
      bin_ff         <= bin_in;
      zend_ff        <= zend_in;
      iss_slot_ff    <= iss_slot_in;
      pend_hash_ff   <= pend_hash_in;
      pend_anchor_ff <= pend_anchor_in;
      out_hash_ff    <= out_hash_in;
      out_anchor_ff  <= out_anchor_in;
      out_last_ff    <= out_last_in;
      out_lost_ff    <= out_lost_in;
   end

   a_count_max: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(WINDOW_DEPTH))
      else $error("window count above depth");

   a_issue_bound: assert property (@(posedge clock) disable iff (reset)
      iss_cnt_ff <= total_ff)
      else $error("scan read past window");

   a_idle_empty: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> (!pend_vld_ff && !chk_vld_ff))
      else $error("held hash or read left over at idle");

   a_store_flushed: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_STORE) |-> !pend_vld_ff)
      else $error("store with held hash");

   a_idle_window: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE && !req.valid) |=> ($stable(count_ff) && $stable(head_ff)))
      else $error("window moved while idle");

endmodule

// ===== rtl/core/landmark_pair_hashing_core.sv =====
`timescale 1ns / 1ps
// The first hash of a peak waits in the pending register until the next hit or the flush moves it out.
// A new peak is accepted only in idle, after the previous peak is stored; the scan
//   reads one anchor per cycle, unless stalled, from the single-read anchor memory.
// A stalled result side holds the scan only when a second hash is ready.
// Reset (synchronous): window empty, sticky flag clear, zone_delay 1, zone_width 32.
// ----------------------------------------------------------------------------
// Landmark pair hashing core
// Pairs each incoming peak with in-zone anchors and emits 48-bit hash words.
// ----------------------------------------------------------------------------
module landmark_pair_hashing_core import lph_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   lph_req_if.sink   req_if,
   lph_rsp_if.source rsp_if,
   lph_csr_if.sink   csr_if
);

   ram_wr_type   ram_wr;
   logic         ram_rd_en;
   slot_type     ram_rd_slot;
   anchor_type   ram_rd_data;
   pair_req_type pair_req;
   pair_res_type pair_res;

   lph_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req         (req_if),
      .rsp         (rsp_if),
      .csr         (csr_if),
      .ram_wr      (ram_wr),
      .ram_rd_en   (ram_rd_en),
      .ram_rd_slot (ram_rd_slot),
      .ram_rd_data (ram_rd_data),
      .pair_req    (pair_req),
      .pair_res    (pair_res)
   );

   lph_anchor_ram u_ram (
      .clock   (clock),
      .wr      (ram_wr),
      .rd_en   (ram_rd_en),
      .rd_slot (ram_rd_slot),
      .rd_data (ram_rd_data)
   );

   lph_pair_unit u_pair (
      .pair_req (pair_req),
      .pair_res (pair_res)
   );

endmodule
